FILE: rtl/skin_weight_top4_normalize_defines.svh
// ----------------------------------------------------------------------------
// skin weight top4 normalize defines
// assertion macros included by the top rtl file, which checks itself
// ----------------------------------------------------------------------------
`ifndef SKIN_WEIGHT_TOP4_NORMALIZE_DEFINES_SVH
`define SKIN_WEIGHT_TOP4_NORMALIZE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SWT4N_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define SWT4N_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: rtl/swt4n_pkg.sv
// ----------------------------------------------------------------------------
// swt4n_pkg
// shared types and constants of the skin weight top4 block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package swt4n_pkg;

  localparam int IDX_W     = 12;
  localparam int JNT_W     = 8;
  localparam int WGT_W     = 17;
  localparam int CNT_W     = 13;
  localparam int OUT_SLOTS = 4;
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [IDX_W-1:0]     vertex;
    logic [JNT_W-1:0]     joint;
    logic [WGT_W-1:0]     weight;
    logic                 bad;
  } op_t;

  typedef struct packed {
    logic                               status;
    logic [IDX_W-1:0]                   vertex;
    logic [OUT_SLOTS-1:0][JNT_W-1:0]    joint;
    logic [OUT_SLOTS-1:0][WGT_W-1:0]    norm;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_LOOK,
    BK_DIV
  } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/swt4n_front.sv
// ----------------------------------------------------------------------------
// swt4n_front
// accepts input transactions, holds vertex_count and flags bad indexes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swt4n_front #(
  parameter int MAX_VERTICES = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [swt4n_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [39:0]               in_tdata,
  input  wire logic [1:0]                in_tuser,
  input  wire swt4n_pkg::queue_status_t  q_status,
  input  wire logic                      init_done,
  output logic                           push,
  output swt4n_pkg::op_t                 op
);
  import swt4n_pkg::*;

  logic [CNT_W-1:0] vertex_count_r;
  logic             idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    idx_ok = (CNT_W'(in_tdata[11:0]) < vertex_count_r) &&
             (17'(in_tdata[11:0]) < 17'(MAX_VERTICES));
    op.action = action_t'(in_tuser);
    op.vertex = in_tdata[11:0];
    op.joint  = in_tdata[19:12];
    op.weight = in_tdata[36:20];
    op.bad    = !idx_ok;
  end

  assign in_tready = !q_status.full && init_done;
  assign push      = in_tvalid && in_tready;

endmodule
`default_nettype wire

FILE: rtl/swt4n_fifo.sv
// ----------------------------------------------------------------------------
// swt4n_fifo
// two-entry queue of classified operations between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swt4n_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire swt4n_pkg::op_t           push_op,
  input  wire logic                     pop,
  output swt4n_pkg::op_t                head_op,
  output swt4n_pkg::queue_status_t      q_status
);
  import swt4n_pkg::*;

  op_t        slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_op;
  end

  assign head_op        = slot_r[rp_r];
  assign q_status.full  = (cnt_r == 2'd2);
  assign q_status.empty = (cnt_r == 2'd0);

endmodule
`default_nettype wire

FILE: rtl/swt4n_back.sv
// ----------------------------------------------------------------------------
// swt4n_back
// vertex store, insertion, clear, and normalizing reads with a serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swt4n_back #(
  parameter int MAX_VERTICES = 4096,
  parameter int SLOTS        = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              op_valid,
  input  wire swt4n_pkg::op_t    op,
  output logic                   op_pop,
  output logic                   init_done,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swt4n_pkg::result_t     result
);
  import swt4n_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int TW = WGT_W + $clog2(SLOTS);
  localparam int NQ = (SLOTS < OUT_SLOTS) ? SLOTS : OUT_SLOTS;
  localparam int JW = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int EW = WGT_W + JNT_W;
  localparam int RW = SLOTS * EW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
  localparam logic [4:0]    LAST_STEP = 5'(WGT_W - 1);
  localparam logic [JW-1:0] LAST_J    = JW'(NQ - 1);

  logic [RW-1:0]    mem [MAX_VERTICES];
  logic [RW-1:0]    rdata_r;
  back_state_t      st_r, st_nxt;
  logic [AW-1:0]    clr_addr_r;
  op_t              op_r;
  logic [TW-1:0]    total_r;
  logic [TW:0]      rem_r;
  logic [WGT_W-1:0] q_r;
  logic [4:0]       step_r;
  logic [JW-1:0]    j_r;
  result_t          res_r;
  logic             out_valid_r;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr;
  logic [RW-1:0]    wr_data, ins_row;
  logic [WGT_W-1:0] wt [SLOTS];
  logic [JNT_W-1:0] jt [SLOTS];
  logic [TW-1:0]    total;
  logic [TW:0]      trial, rem_nxt;
  logic             qbit, seen;
  logic [EW-1:0]    prev;

  // unpack the registered row, build insertion and sum
  always_comb begin
    seen  = 1'b0;
    prev  = '0;
    total = '0;
    ins_row = rdata_r;
    for (int s = 0; s < SLOTS; s++) begin
      wt[s] = rdata_r[s*EW +: WGT_W];
      jt[s] = rdata_r[s*EW + WGT_W +: JNT_W];
      total = total + TW'(wt[s]);
      if (seen) begin
        ins_row[s*EW +: EW] = prev;
      end else if (op_r.weight > wt[s]) begin
        ins_row[s*EW +: EW] = {op_r.joint, op_r.weight};
        seen = 1'b1;
      end
      prev = rdata_r[s*EW +: EW];
    end
  end

  // one restoring division step
  always_comb begin
    trial   = {rem_r[TW-1:0], (step_r == 5'd0) ? wt[j_r][0] : 1'b0};
    qbit    = (trial >= {1'b0, total_r});
    rem_nxt = qbit ? (trial - {1'b0, total_r}) : trial;
  end

  always_comb begin
    st_nxt  = st_r;
    op_pop  = 1'b0;
    wr_en   = 1'b0;
    wr_addr = AW'(op.vertex);
    wr_data = '0;
    rd_en   = 1'b0;
    case (st_r)
      BK_INIT: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        if (clr_addr_r == LAST_ADDR) st_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (op_valid && !out_valid_r) begin
          op_pop = 1'b1;
          if (!op.bad && (op.action == ACT_ADD || op.action == ACT_READ)) begin
            rd_en  = 1'b1;
            st_nxt = BK_LOOK;
          end else if (!op.bad && op.action == ACT_CLEAR) begin
            wr_en = 1'b1;
          end
        end
      end
      BK_LOOK: begin
        if (op_r.action == ACT_ADD) begin
          wr_en   = 1'b1;
          wr_addr = AW'(op_r.vertex);
          wr_data = ins_row;
          st_nxt  = BK_IDLE;
        end else if (total == '0) begin
          st_nxt = BK_IDLE;
        end else begin
          st_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == LAST_STEP && j_r == LAST_J) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[AW'(op.vertex)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_INIT;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_INIT) clr_addr_r <= clr_addr_r + 1'b1;
      if (out_ready) out_valid_r <= 1'b0;
      if ((st_r == BK_IDLE && op_pop && !rd_en) ||
          (st_r == BK_LOOK && st_nxt == BK_IDLE) ||
          (st_r == BK_DIV && st_nxt == BK_IDLE)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        if (op_pop) begin
          op_r          <= op;
          res_r         <= '0;
          res_r.vertex  <= op.vertex;
          res_r.status  <= op.bad && (op.action != ACT_NONE);
        end
      end
      BK_LOOK: begin
        total_r <= total;
        rem_r   <= (TW+1)'(wt[0] >> 1);
        step_r  <= '0;
        j_r     <= '0;
        if (op_r.action == ACT_READ) begin
          if (total == '0) begin
            res_r.status <= 1'b1;
          end else begin
            for (int s = 0; s < NQ; s++) res_r.joint[s] <= jt[s];
          end
        end
      end
      BK_DIV: begin
        q_r <= {q_r[WGT_W-2:0], qbit};
        if (step_r == LAST_STEP) begin
          res_r.norm[j_r] <= {q_r[WGT_W-2:0], qbit};
          step_r <= '0;
          j_r    <= j_r + 1'b1;
          rem_r  <= (TW+1)'(wt[(j_r == LAST_J) ? j_r : j_r + 1'b1] >> 1);
        end else begin
          step_r <= step_r + 1'b1;
          rem_r  <= rem_nxt;
        end
      end
      default: ;
    endcase
  end

  assign init_done = (st_r != BK_INIT);
  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule
`default_nettype wire

FILE: rtl/skin_weight_top4_normalize.sv
// ----------------------------------------------------------------------------
// skin_weight_top4_normalize
// per-vertex top joint influence store with normalized read-back
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser
//  in_     | slave     | vertex, joint, weight          | action
//  out_    | master    | vertex, joints a-d, norms a-d  | status
//  cfg_    | write     | vertex_count                   | -
//
//  an add pops with the row read, then writes the row back; clear and
//  rejected transactions finish at the pop; a read pops with the row read,
//  then forms min(4, SLOTS) norms of a nonzero row, one quotient bit per
//  cycle in the shared divider; the single memory port pair sets the add rate
//  after reset a clearing pass writes MAX_VERTICES rows, one per cycle,
//  with in_tready low; cfg writes are taken during it
//  a stalled output only stops the back end, which pops nothing while a
//  result waits; the front queue keeps taking transactions until both of its entries are full
`timescale 1ns / 1ps
`default_nettype none
`include "skin_weight_top4_normalize_defines.svh"
module skin_weight_top4_normalize #(
  parameter int MAX_VERTICES = 4096,
  parameter int SLOTS        = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [12:0]   cfg_wr_data,   // vertex_count
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [39:0]   in_tdata,      // vertex_index, joint_index, weight
  input  wire logic [1:0]    in_tuser,      // action
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // out_vertex, joint_a, joint_b, joint_c, joint_d, norm_a, norm_b, norm_c, norm_d
  output logic [111:0]       out_tdata,
  output logic               out_tuser      // status
);
  import swt4n_pkg::*;

  queue_status_t q_status;
  op_t           push_op, head_op;
  logic          push, pop, init_done;
  result_t       res;

  // front: config register and index check
  swt4n_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_status(q_status), .init_done(init_done),
    .push(push), .op(push_op)
  );

  // queue decoupling classify from execute
  swt4n_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_op(push_op),
    .pop(pop), .head_op(head_op), .q_status(q_status)
  );

  // back: store, insert, divide
  swt4n_back #(.MAX_VERTICES(MAX_VERTICES), .SLOTS(SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .op_valid(!q_status.empty), .op(head_op), .op_pop(pop),
    .init_done(init_done),
    .out_valid(out_tvalid), .out_ready(out_tready), .result(res)
  );

  assign out_tdata = {res.norm, res.joint, res.vertex};
  assign out_tuser = res.status;

  // no transaction taken while the store is being cleared
  `SWT4N_ASSERT_IMPL(a_no_accept_in_init, in_tready, init_done)
  // queue is never pushed past its depth
  `SWT4N_ASSERT_IMPL(a_no_push_full, push, !q_status.full)
  // a failed result carries zero joints and norms
  `SWT4N_ASSERT_IMPL(a_fail_zero, out_tvalid && out_tuser, out_tdata[111:12] == '0)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin weight top4 normalize testbench
// drives add, read, clear and unused transactions into the influence store
// under several vertex_count settings, predicts every result from a private
// copy of the per-vertex slot lists and checks it field by field
// ----------------------------------------------------------------------------
module testbench;
  import swt4n_pkg::*;

  localparam int NVERT = 4096;
  localparam int NSLOT = 4;

  // one expected result, slot 0 is the strongest
  typedef struct {
    bit                         status;
    bit [IDX_W-1:0]             vertex;
    bit [NSLOT-1:0][JNT_W-1:0]  joint;
    bit [NSLOT-1:0][WGT_W-1:0]  norm;
  } vertex_result_t;

  // keeps the top four influences of every vertex and the results they imply
  class top4_tracker;
    bit [WGT_W-1:0] wgt [NVERT][NSLOT];
    bit [JNT_W-1:0] jnt [NVERT][NSLOT];
    bit [CNT_W-1:0] vcount;
    vertex_result_t pending_results [$];
    int errors;

    function new();
      foreach (wgt[v, s]) begin
        wgt[v][s] = '0;
        jnt[v][s] = '0;
      end
      vcount = COUNT_RESET;
      errors = 0;
    endfunction

    function void set_count(bit [CNT_W-1:0] c);
      vcount = c;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_input(action_t act, bit [IDX_W-1:0] v, bit [JNT_W-1:0] j,
                             bit [WGT_W-1:0] w);
      vertex_result_t r;
      bit [63:0] total;
      bit done;
      r.status = 1'b0;
      r.vertex = v;
      r.joint  = '0;
      r.norm   = '0;
      done     = 1'b0;
      total    = '0;
      if (act == ACT_NONE) begin
        // ignored, only the echo comes back
      end else if (!(v < vcount && v < NVERT)) begin
        r.status = 1'b1;
      end else begin
        case (act)
          ACT_ADD: begin
            // insert at the first strictly weaker slot, weakest drops out
            for (int s = 0; s < NSLOT; s++) begin
              if (!done && w > wgt[v][s]) begin
                for (int m = NSLOT - 1; m > s; m--) begin
                  wgt[v][m] = wgt[v][m-1];
                  jnt[v][m] = jnt[v][m-1];
                end
                wgt[v][s] = w;
                jnt[v][s] = j;
                done = 1'b1;
              end
            end
          end
          ACT_CLEAR: begin
            for (int s = 0; s < NSLOT; s++) begin
              wgt[v][s] = '0;
              jnt[v][s] = '0;
            end
          end
          default: begin
            for (int s = 0; s < NSLOT; s++) total += wgt[v][s];
            if (total == 0) begin
              r.status = 1'b1;
            end else begin
              for (int s = 0; s < NSLOT; s++) begin
                r.joint[s] = jnt[v][s];
                r.norm[s]  = WGT_W'((64'(wgt[v][s]) << 16) / total);
              end
            end
          end
        endcase
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic status, logic [111:0] data);
      vertex_result_t e;
      bit bad;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: vertex %0d", data[11:0]);
        return;
      end
      e = pending_results.pop_front();
      bad = (status !== e.status) || (data[11:0] !== e.vertex);
      for (int s = 0; s < NSLOT; s++) begin
        if (data[12 + 8*s +: 8] !== e.joint[s]) bad = 1'b1;
        if (data[44 + 17*s +: 17] !== e.norm[s]) bad = 1'b1;
      end
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected status %0d vertex %0d joints %p norms %p",
                   e.status, e.vertex, e.joint, e.norm);
          $display("          actual   status %0d vertex %0d data %h",
                   status, data[11:0], data[111:12]);
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [12:0]  cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;      // vertex_index, joint_index, weight
  logic [1:0]   in_tuser = '0;      // action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;          // vertex, joint a-d, norm a-d
  logic         out_tuser;          // status

  top4_tracker trk = new();

  // no random idling on either side while set
  bit calm = 1'b0;
  // stimulus asks the receiver for a long hold-off through this flag
  bit hold_start = 1'b0;
  int hold_left = 0;

  always #5 clk = ~clk;

  skin_weight_top4_normalize dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // transaction monitor: inputs are noted before results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        trk.note_input(action_t'(in_tuser), in_tdata[11:0], in_tdata[19:12],
                       in_tdata[36:20]);
      if (out_tvalid && out_tready)
        trk.check_result(out_tuser, out_tdata);
    end
  end

  // result receiver with random stalls and one long hold-off on request
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left  = 400;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  // offers one transaction, called and returning just after a falling edge
  task automatic send_item(action_t act, bit [IDX_W-1:0] v, bit [JNT_W-1:0] j,
                           bit [WGT_W-1:0] w);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, w, j, v};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // drops valid and waits until every expected result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(bit [CNT_W-1:0] c);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    trk.set_count(c);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly well-formed traffic on a small pool of valid vertices so the
  // slot lists fill up, with some stray indexes and unused actions
  task automatic random_item(int pool_base, int pool_size);
    int r;
    bit [IDX_W-1:0] v;
    bit [WGT_W-1:0] w;
    action_t act;
    r = $urandom_range(0, 99);
    if (r < 55) act = ACT_ADD;
    else if (r < 82) act = ACT_READ;
    else if (r < 94) act = ACT_CLEAR;
    else act = ACT_NONE;
    if (pool_size > 0 && $urandom_range(0, 99) < 85)
      v = IDX_W'(pool_base + int'($urandom_range(0, pool_size - 1)));
    else
      v = IDX_W'($urandom_range(0, NVERT - 1));
    r = $urandom_range(0, 9);
    if (r == 0) w = '0;
    else if (r == 1) w = WGT_W'($urandom_range(65537, 131071));
    else if (r == 2) w = 17'd65536;
    else w = WGT_W'($urandom_range(1, 65535));
    send_item(act, v, JNT_W'($urandom_range(0, 255)), w);
  endtask

  initial begin
    int counts [6] = '{5, 0, 8191, 1, 2500, 4096};
    int sizes  [6] = '{200, 60, 220, 200, 220, 200};
    int lim;
    int pool_size;
    int pool_base;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ordering, ties, overflow weight, extremes, zero total
    send_item(ACT_ADD,   0,    0,   100);
    send_item(ACT_ADD,   0,    255, 65536);
    send_item(ACT_ADD,   0,    7,   100);
    send_item(ACT_ADD,   0,    9,   50);
    send_item(ACT_ADD,   0,    3,   131071);
    send_item(ACT_READ,  0,    0,   0);
    send_item(ACT_ADD,   0,    1,   0);
    send_item(ACT_READ,  0,    0,   0);
    send_item(ACT_READ,  1,    0,   0);
    send_item(ACT_ADD,   4095, 254, 1);
    send_item(ACT_READ,  4095, 0,   0);
    send_item(ACT_CLEAR, 0,    0,   0);
    send_item(ACT_READ,  0,    0,   0);
    send_item(ACT_NONE,  5,    255, 131071);
    send_item(ACT_CLEAR, 4095, 0,   0);
    send_item(ACT_READ,  4095, 0,   0);
    send_item(ACT_ADD,   4,    2,   1);
    send_item(ACT_ADD,   4,    6,   131071);
    send_item(ACT_READ,  4,    0,   0);
    wait_drained();

    // random phases under several vertex counts
    foreach (counts[p]) begin
      write_count(CNT_W'(counts[p]));
      lim = (counts[p] < NVERT) ? counts[p] : NVERT;
      pool_size = (lim < 8) ? lim : 8;
      pool_base = (lim > pool_size) ? $urandom_range(0, lim - pool_size) : 0;
      if (p == 2) pool_base = NVERT - pool_size;
      calm = (p == 3);
      for (int i = 0; i < sizes[p]; i++) begin
        if (p == 2 && i == 80) hold_start = 1'b1;
        if (p == 0 && i == 100) wait_drained();
        random_item(pool_base, pool_size);
      end
      calm = 1'b0;
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: skin_weight_top4_normalize.f
+incdir+rtl
rtl/swt4n_pkg.sv
rtl/swt4n_front.sv
rtl/swt4n_fifo.sv
rtl/swt4n_back.sv
rtl/skin_weight_top4_normalize.sv
tb/testbench.sv
